FILE: hdl/sha256_pkg.sv
// sha-256 shared types, round constants and hash functions
// used by every module of the sha-256 message digest block
`default_nettype none
package sha256_pkg;

	localparam int WordW = 32;
	localparam int Rounds = 64;
	localparam int HashWords = 8;
	localparam int BlockWords = 16;

	typedef logic [WordW-1:0] word_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_P80, ST_PZ, ST_LEN, ST_INIT, ST_ROUND, ST_FINAL, ST_OUT
	} state_t;

	typedef enum logic [1:0] {RET_IDLE, RET_P80, RET_PZ, RET_OUT} ret_t;

	typedef enum logic [1:0] {SEL_DATA, SEL_80, SEL_ZERO} byte_sel_t;

	localparam logic [7:0] PadByte = 8'h80;

	typedef struct packed {
		logic      put;
		byte_sel_t sel;
		logic      count;
		logic      write_len;
		logic      comp_init;
		logic      round;
		logic      final_add;
		logic      out_step;
		logic      reload;
	} dp_cmd_t;

	typedef struct packed {
		logic fill_last;
		logic fill_56;
		logic round_last;
		logic out_last;
	} dp_stat_t;

	function automatic word_t init_hash(input logic [2:0] i);
		word_t r;
		unique case (i)
			3'd0: r = 32'h6a09e667;
			3'd1: r = 32'hbb67ae85;
			3'd2: r = 32'h3c6ef372;
			3'd3: r = 32'ha54ff53a;
			3'd4: r = 32'h510e527f;
			3'd5: r = 32'h9b05688c;
			3'd6: r = 32'h1f83d9ab;
			default: r = 32'h5be0cd19;
		endcase
		return r;
	endfunction

	function automatic word_t round_k(input logic [5:0] i);
		word_t r;
		unique case (i)
			6'd0: r = 32'h428a2f98;  6'd1: r = 32'h71374491;
			6'd2: r = 32'hb5c0fbcf;  6'd3: r = 32'he9b5dba5;
			6'd4: r = 32'h3956c25b;  6'd5: r = 32'h59f111f1;
			6'd6: r = 32'h923f82a4;  6'd7: r = 32'hab1c5ed5;
			6'd8: r = 32'hd807aa98;  6'd9: r = 32'h12835b01;
			6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
			6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
			6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
			6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
			6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
			6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
			6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
			6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
			6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
			6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
			6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
			6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
			6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
			6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
			6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
			6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
			6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
			6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
			6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
			6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
			6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
			6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
			6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
			6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
			6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
			6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
			6'd62: r = 32'hbef9a3f7; default: r = 32'hc67178f2;
		endcase
		return r;
	endfunction

	function automatic word_t ror(input word_t x, input int s);
		return (x >> s) | (x << (WordW - s));
	endfunction

	function automatic word_t bsig0(input word_t x);
		return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
	endfunction

	function automatic word_t bsig1(input word_t x);
		return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
	endfunction

	function automatic word_t ssig0(input word_t x);
		return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t ssig1(input word_t x);
		return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
	endfunction

endpackage
`default_nettype wire

FILE: hdl/sha256_if.sv
// valid/ready channel interfaces for message bytes and digest words
// depends on nothing
`default_nettype none
interface sha256_msg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       has_byte;
	logic       end_of_message;
	modport source(output valid, data_byte, has_byte, end_of_message, input ready);
	modport sink(input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

interface sha256_dig_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;
	modport source(output valid, digest_word, word_index, last_word, input ready);
	modport sink(input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

FILE: hdl/sha256_ctrl.sv
// sha-256 sequencer: byte intake, padding, compression and word output
// depends on sha256_pkg
`default_nettype none
module sha256_ctrl
	import sha256_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     msg_valid,
	input  wire logic     msg_has_byte,
	input  wire logic     msg_eom,
	output logic          msg_ready,
	output logic          dig_valid,
	input  wire logic     dig_ready,
	input  wire dp_stat_t stat,
	output dp_cmd_t       cmd
);

	state_t state_q, state_d;
	ret_t   ret_q, ret_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q   <= RET_IDLE;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ret_d     = ret_q;
		cmd       = '0;
		cmd.sel   = SEL_DATA;
		msg_ready = 1'b0;
		dig_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				msg_ready = 1'b1;
				if (msg_valid) begin
					cmd.put   = msg_has_byte;
					cmd.count = msg_has_byte;
					if (msg_has_byte && stat.fill_last) begin
						state_d = ST_INIT;
						ret_d   = msg_eom ? RET_P80 : RET_IDLE;
					end else if (msg_eom) begin
						state_d = ST_P80;
					end
				end
			end
			ST_P80: begin
				cmd.put = 1'b1;
				cmd.sel = SEL_80;
				if (stat.fill_last) begin
					state_d = ST_INIT;
					ret_d   = RET_PZ;
				end else begin
					state_d = ST_PZ;
				end
			end
			ST_PZ: begin
				if (stat.fill_56) begin
					state_d = ST_LEN;
				end else begin
					cmd.put = 1'b1;
					cmd.sel = SEL_ZERO;
					if (stat.fill_last) begin
						state_d = ST_INIT;
						ret_d   = RET_PZ;
					end
				end
			end
			ST_LEN: begin
				cmd.write_len = 1'b1;
				state_d       = ST_INIT;
				ret_d         = RET_OUT;
			end
			ST_INIT: begin
				cmd.comp_init = 1'b1;
				state_d       = ST_ROUND;
			end
			ST_ROUND: begin
				cmd.round = 1'b1;
				if (stat.round_last) begin
					state_d = ST_FINAL;
				end
			end
			ST_FINAL: begin
				cmd.final_add = 1'b1;
				unique case (ret_q)
					RET_IDLE: state_d = ST_IDLE;
					RET_P80:  state_d = ST_P80;
					RET_PZ:   state_d = ST_PZ;
					RET_OUT:  state_d = ST_OUT;
					default:  state_d = ST_IDLE;
				endcase
			end
			ST_OUT: begin
				dig_valid = 1'b1;
				if (dig_ready) begin
					cmd.out_step = 1'b1;
					if (stat.out_last) begin
						cmd.reload = 1'b1;
						state_d    = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule
`default_nettype wire

FILE: hdl/sha256_dp.sv
// sha-256 datapath: block window, hash and working registers, length counter
// depends on sha256_pkg
`default_nettype none
module sha256_dp
	import sha256_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire dp_cmd_t    cmd,
	input  wire logic [7:0] data_byte,
	output dp_stat_t        stat,
	output word_t           digest_word,
	output logic [2:0]      word_index
);

	word_t       blk_q [BlockWords];
	word_t       hash_q [HashWords];
	word_t       v_q [HashWords];
	logic [5:0]  fill_q;
	logic [63:0] bits_q;
	logic [5:0]  rnd_q;
	logic [2:0]  widx_q;

	logic [7:0] byte_v;
	logic [3:0] widx;
	logic [4:0] sh;
	word_t      base, t1, t2, w16;

	always_comb begin
		unique case (cmd.sel)
			SEL_DATA: byte_v = data_byte;
			SEL_80:   byte_v = PadByte;
			default:  byte_v = 8'h00;
		endcase
		widx = fill_q[5:2];
		sh   = 5'd24 - {fill_q[1:0], 3'b000};
		// first byte of a word clears the rest of it
		base = (fill_q[1:0] == 2'b00) ? '0 : blk_q[widx];
		t1   = v_q[7] + bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
			+ round_k(rnd_q) + blk_q[0];
		t2   = bsig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
		w16  = ssig1(blk_q[14]) + blk_q[9] + ssig0(blk_q[1]) + blk_q[0];
	end

	// block window shifts one word per round, word 0 is the current schedule word
	always_ff @(posedge clk) begin
		if (cmd.round) begin
			for (int i = 0; i < BlockWords - 1; i++) begin
				blk_q[i] <= blk_q[i+1];
			end
			blk_q[BlockWords-1] <= w16;
		end else if (cmd.write_len) begin
			blk_q[14] <= bits_q[63:32];
			blk_q[15] <= bits_q[31:0];
		end else if (cmd.put) begin
			blk_q[widx] <= base | (word_t'(byte_v) << sh);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.comp_init) begin
			for (int i = 0; i < HashWords; i++) begin
				v_q[i] <= hash_q[i];
			end
			rnd_q <= '0;
		end else if (cmd.round) begin
			v_q[0] <= t1 + t2;
			v_q[1] <= v_q[0];
			v_q[2] <= v_q[1];
			v_q[3] <= v_q[2];
			v_q[4] <= v_q[3] + t1;
			v_q[5] <= v_q[4];
			v_q[6] <= v_q[5];
			v_q[7] <= v_q[6];
			rnd_q  <= rnd_q + 6'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HashWords; i++) begin
				hash_q[i] <= init_hash(3'(i));
			end
			fill_q <= '0;
			bits_q <= '0;
			widx_q <= '0;
		end else begin
			if (cmd.final_add) begin
				for (int i = 0; i < HashWords; i++) begin
					hash_q[i] <= hash_q[i] + v_q[i];
				end
			end else if (cmd.reload) begin
				for (int i = 0; i < HashWords; i++) begin
					hash_q[i] <= init_hash(3'(i));
				end
			end
			if (cmd.write_len) begin
				fill_q <= '0;
			end else if (cmd.put) begin
				fill_q <= fill_q + 6'd1;
			end
			if (cmd.reload) begin
				bits_q <= '0;
			end else if (cmd.count) begin
				bits_q <= bits_q + 64'd8;
			end
			if (cmd.out_step) begin
				widx_q <= widx_q + 3'd1;
			end
		end
	end

	assign stat.fill_last  = (fill_q == 6'd63);
	assign stat.fill_56    = (fill_q == 6'd56);
	assign stat.round_last = (rnd_q == 6'(Rounds - 1));
	assign stat.out_last   = (widx_q == 3'd7);
	assign digest_word     = hash_q[widx_q];
	assign word_index      = widx_q;

endmodule
`default_nettype wire

FILE: hdl/sha256_message_digest_top.sv
// sha-256 message digest: one message byte per word in, eight digest words out
// one byte per cycle in idle; a full block stalls intake (load, 64 rounds, add)
// end of message: one pad byte per cycle outside compression, the length,
// one or two blocks, then 8 digest words, one per cycle while the sink takes them
// arst_n loads the initial hash and clears fill and bit count
`default_nettype none
module sha256_message_digest_top
	import sha256_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	sha256_msg_if.sink   msg,
	sha256_dig_if.source dig
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	sha256_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.msg_valid    (msg.valid),
		.msg_has_byte (msg.has_byte),
		.msg_eom      (msg.end_of_message),
		.msg_ready    (msg.ready),
		.dig_valid    (dig.valid),
		.dig_ready    (dig.ready),
		.stat         (stat),
		.cmd          (cmd)
	);

	sha256_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.data_byte   (msg.data_byte),
		.stat        (stat),
		.digest_word (dig.digest_word),
		.word_index  (dig.word_index)
	);

	assign dig.last_word = stat.out_last;

endmodule
`default_nettype wire
